FILE: rtl/escdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped ASCII decoder package
// Shared types and character constants for the escaped ASCII to UTF-16
// decoder: decode modes, status codes and the state and result records.
// ----------------------------------------------------------------------------
package escdec_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int UNIT_WIDTH = 16;

   // characters that steer the decoder
   localparam logic [BYTE_WIDTH-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_U   = 8'h55;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [BYTE_WIDTH-1:0] CHAR_DIGIT_0   = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_DIGIT_9   = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] CASE_OFFSET    = 8'h20;
   // hex letter value is its low nibble plus this (A is 0x41, value 10)
   localparam logic [3:0]            HEX_LETTER_ADJ = 4'd9;

   // decode mode, also the state of the escape sequencer
   typedef enum logic [3:0] {
      MODE_PLAIN     = 4'd0,
      MODE_BACKSLASH = 4'd1,
      MODE_HEX_1     = 4'd2,
      MODE_HEX_2     = 4'd3,
      MODE_HEX_3     = 4'd4,
      MODE_HEX_4     = 4'd5,
      MODE_OCT_2     = 4'd7,
      MODE_OCT_3     = 4'd8,
      MODE_ERROR     = 4'd15
   } mode_type;

   // per-request stream status
   typedef enum logic [1:0] {
      STATUS_RUNNING       = 2'd0,
      STATUS_ERROR_SEEN    = 2'd1,
      STATUS_ENDED_VALID   = 2'd2,
      STATUS_ENDED_INVALID = 2'd3
   } status_type;

   typedef struct packed {
      mode_type              mode;
      logic [UNIT_WIDTH-1:0] partial_value;
   } state_type;

   typedef struct packed {
      logic [UNIT_WIDTH-1:0] code_unit;
      logic                  unit_valid;
      status_type            status;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/escdec_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped ASCII decoder request channel
// Valid/ready channel carrying one raw byte of the escaped stream.
// ----------------------------------------------------------------------------
interface escdec_req_if;
   logic                                valid;
   logic                                ready;
   logic [escdec_pkg::BYTE_WIDTH-1:0]   byte_in;
   logic                                last;

   modport source (output valid, output byte_in, output last, input ready);
   modport sink   (input valid, input byte_in, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/escdec_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped ASCII decoder response channel
// Valid/ready channel carrying one decoded code unit and the stream status.
// ----------------------------------------------------------------------------
interface escdec_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [escdec_pkg::UNIT_WIDTH-1:0]   code_unit;
   logic                                unit_valid;
   logic [1:0]                          status;

   modport source (output valid, output code_unit, output unit_valid, output status,
                   input ready);
   modport sink   (input valid, input code_unit, input unit_valid, input status,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/escdec_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped ASCII decoder step
// Combinational decode of one byte: next mode and partial value, the
// finished code unit and the stream status.
// ----------------------------------------------------------------------------
module escdec_step (
   input  wire escdec_pkg::state_type            state_cur,
   input  wire logic [escdec_pkg::BYTE_WIDTH-1:0] byte_in,
   input  wire logic                             last,
   output escdec_pkg::state_type                 state_next,
   output escdec_pkg::result_type                result
);

   logic                                 is_digit;
   logic [escdec_pkg::BYTE_WIDTH-1:0]    upper_byte;
   logic                                 is_hex_letter;
   logic                                 is_hex;
   logic [3:0]                           hex_value;
   logic [escdec_pkg::UNIT_WIDTH-1:0]    hex_merged;
   logic [escdec_pkg::UNIT_WIDTH-1:0]    oct_merged;
   logic                                 emit;

   // digit classification, letters folded to upper case
   always_comb begin
      is_digit      = (byte_in >= escdec_pkg::CHAR_DIGIT_0) &&
                      (byte_in <= escdec_pkg::CHAR_DIGIT_9);
      upper_byte    = (byte_in >= escdec_pkg::CHAR_LOWER_A) ?
                      (byte_in - escdec_pkg::CASE_OFFSET) : byte_in;
      is_hex_letter = (upper_byte >= escdec_pkg::CHAR_UPPER_A) &&
                      (upper_byte <= escdec_pkg::CHAR_UPPER_F);
      is_hex        = is_digit || is_hex_letter;
      hex_value     = is_digit ? byte_in[3:0] : (upper_byte[3:0] + escdec_pkg::HEX_LETTER_ADJ);
      hex_merged    = {state_cur.partial_value[escdec_pkg::UNIT_WIDTH-5:0], hex_value};
      // octal digits are or-ed in, so 8 and 9 bleed into the upper bit
      oct_merged    = {state_cur.partial_value[escdec_pkg::UNIT_WIDTH-4:0], 3'b000} |
                      {{(escdec_pkg::UNIT_WIDTH-4){1'b0}}, byte_in[3:0]};
   end

   // next mode and partial value
   always_comb begin
      state_next = state_cur;
      unique case (state_cur.mode)
         escdec_pkg::MODE_PLAIN: begin
            if (byte_in == escdec_pkg::CHAR_BACKSLASH) begin
               state_next.mode = escdec_pkg::MODE_BACKSLASH;
            end else if (!byte_in[escdec_pkg::BYTE_WIDTH-1]) begin
               state_next.partial_value = {{(escdec_pkg::UNIT_WIDTH-escdec_pkg::BYTE_WIDTH){1'b0}},
                                           byte_in};
            end else begin
               state_next.mode = escdec_pkg::MODE_ERROR;
            end
         end
         escdec_pkg::MODE_BACKSLASH: begin
            if (byte_in == escdec_pkg::CHAR_UPPER_U || byte_in == escdec_pkg::CHAR_LOWER_U) begin
               state_next.mode          = escdec_pkg::MODE_HEX_1;
               state_next.partial_value = '0;
            end else if (is_digit) begin
               state_next.mode          = escdec_pkg::MODE_OCT_2;
               state_next.partial_value = {{(escdec_pkg::UNIT_WIDTH-4){1'b0}}, byte_in[3:0]};
            end else if (byte_in == escdec_pkg::CHAR_BACKSLASH) begin
               state_next.mode          = escdec_pkg::MODE_PLAIN;
               state_next.partial_value = {{(escdec_pkg::UNIT_WIDTH-escdec_pkg::BYTE_WIDTH){1'b0}},
                                           byte_in};
            end else begin
               state_next.mode = escdec_pkg::MODE_ERROR;
            end
         end
         escdec_pkg::MODE_HEX_1, escdec_pkg::MODE_HEX_2,
         escdec_pkg::MODE_HEX_3, escdec_pkg::MODE_HEX_4: begin
            if (is_hex) begin
               state_next.partial_value = hex_merged;
               unique case (state_cur.mode)
                  escdec_pkg::MODE_HEX_1: state_next.mode = escdec_pkg::MODE_HEX_2;
                  escdec_pkg::MODE_HEX_2: state_next.mode = escdec_pkg::MODE_HEX_3;
                  escdec_pkg::MODE_HEX_3: state_next.mode = escdec_pkg::MODE_HEX_4;
                  default:                state_next.mode = escdec_pkg::MODE_PLAIN;
               endcase
            end else begin
               state_next.mode = escdec_pkg::MODE_ERROR;
            end
         end
         escdec_pkg::MODE_OCT_2, escdec_pkg::MODE_OCT_3: begin
            if (is_digit) begin
               state_next.partial_value = oct_merged;
               state_next.mode = (state_cur.mode == escdec_pkg::MODE_OCT_2) ?
                                 escdec_pkg::MODE_OCT_3 : escdec_pkg::MODE_PLAIN;
            end else begin
               state_next.mode = escdec_pkg::MODE_ERROR;
            end
         end
         default: begin
            state_next.mode = escdec_pkg::MODE_ERROR;
         end
      endcase
   end

   // code unit and status
   always_comb begin
      emit = (state_cur.mode != escdec_pkg::MODE_ERROR) &&
             (state_next.mode == escdec_pkg::MODE_PLAIN);
      result.unit_valid = emit;
      result.code_unit  = emit ? state_next.partial_value : '0;
      if (last) begin
         result.status = (state_next.mode == escdec_pkg::MODE_PLAIN) ?
                         escdec_pkg::STATUS_ENDED_VALID : escdec_pkg::STATUS_ENDED_INVALID;
      end else begin
         result.status = (state_next.mode == escdec_pkg::MODE_ERROR) ?
                         escdec_pkg::STATUS_ERROR_SEEN : escdec_pkg::STATUS_RUNNING;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/escaped_ascii_to_utf16_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// The response to an accepted request is held in the output register.
// Throughput: one request per cycle while responses are taken; the decode of a byte is one pass of the step logic.
// The request side stays ready while the response register is empty or being taken.
// Reset (synchronous): plain mode, zero partial value, no response pending.
// ----------------------------------------------------------------------------
// Escaped ASCII to UTF-16 decoder
// Decodes backslash, hex and octal escapes byte by byte into 16-bit code
// units, with a sticky error and an end-of-stream status.
// ----------------------------------------------------------------------------
module escaped_ascii_to_utf16_decoder (
   input  wire logic          clock,
   input  wire logic          reset,
   escdec_req_if.sink         req_ch,
   escdec_rsp_if.source       rsp_ch
);

   escdec_pkg::state_type     state_ff;
   escdec_pkg::state_type     state_in;
   escdec_pkg::state_type     step_state;
   escdec_pkg::result_type    step_result;
   escdec_pkg::result_type    result_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      req_accept;

   // request handshake: take a byte whenever the output register frees up
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   escdec_step u_step (
      .state_cur  (state_ff),
      .byte_in    (req_ch.byte_in),
      .last       (req_ch.last),
      .state_next (step_state),
      .result     (step_result)
   );

   // next decoder state, cleared at the end of a stream
   always_comb begin
      state_in = state_ff;
      if (req_accept) begin
         if (req_ch.last) begin
            state_in.mode          = escdec_pkg::MODE_PLAIN;
            state_in.partial_value = '0;
         end else begin
            state_in = step_state;
         end
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode          <= escdec_pkg::MODE_PLAIN;
         state_ff.partial_value <= '0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= step_result;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.code_unit  = result_ff.code_unit;
   assign rsp_ch.unit_valid = result_ff.unit_valid;
   assign rsp_ch.status     = result_ff.status;

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped ASCII to UTF-16 decoder testbench
// Drives byte streams into the decoder through its valid/ready request
// channel and checks every response against a cycle-free model of the
// decode. A short table covers plain bytes, backslash pairs, hex and octal
// escapes, sticky errors and end-of-stream status. It is followed by random
// streams, mostly well formed with some broken, under random idling on both
// sides and one long hold-off on the response side.
// ----------------------------------------------------------------------------
module tb;

   localparam int HALF_PERIOD = 6;
   localparam int ITEM_TARGET = 1820;
   localparam int HOLD_AFTER  = 300;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 800000;
   localparam int DIRECTED_ROWS = 26;

   // kinds of well-formed token in a random stream
   typedef enum int {
      TOKEN_PLAIN,
      TOKEN_PAIR,
      TOKEN_HEX,
      TOKEN_OCTAL
   } token_kind_type;

   // one row of the directed table; pinned rows carry their response
   typedef struct packed {
      logic [escdec_pkg::BYTE_WIDTH-1:0] data;
      logic                              last;
      logic                              pinned;
      escdec_pkg::result_type            want;
   } stim_row_type;

   logic clock;
   logic reset;

   escdec_req_if req_ch ();
   escdec_rsp_if rsp_ch ();

   escaped_ascii_to_utf16_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // decoder state as the checker sees it
   escdec_pkg::mode_type              dec_mode;
   logic [escdec_pkg::UNIT_WIDTH-1:0] dec_value;

   escdec_pkg::result_type            expected_results [$];
   logic [escdec_pkg::BYTE_WIDTH-1:0] stream_bytes [$];
   int                                failures;
   int                                sent_requests;
   int                                cycle_count;
   bit                                quiet;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, '{16'h0000, 1'b1, escdec_pkg::STATUS_RUNNING}}, // lowest byte
      '{8'h7F, 1'b0, 1'b1, '{16'h007F, 1'b1, escdec_pkg::STATUS_RUNNING}}, // highest plain
      '{8'h5C, 1'b0, 1'b1, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}},
      '{8'h5C, 1'b0, 1'b1, '{16'h005C, 1'b1, escdec_pkg::STATUS_RUNNING}}, // backslash pair
      '{8'h5C, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}},
      '{8'h75, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}}, // u
      '{8'h30, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}}, // 0
      '{8'h61, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}}, // a
      '{8'h46, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}}, // F
      '{8'h39, 1'b0, 1'b1, '{16'h0AF9, 1'b1, escdec_pkg::STATUS_RUNNING}}, // 9
      '{8'h5C, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}},
      '{8'h55, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}}, // U
      '{8'h66, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}},
      '{8'h66, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}},
      '{8'h66, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}},
      '{8'h66, 1'b0, 1'b1, '{16'hFFFF, 1'b1, escdec_pkg::STATUS_RUNNING}}, // largest unit
      '{8'h5C, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}},
      '{8'h39, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}}, // octal with 9s
      '{8'h39, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}},
      '{8'h37, 1'b0, 1'b0, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}},
      '{8'hFF, 1'b0, 1'b1, '{16'h0000, 1'b0, escdec_pkg::STATUS_ERROR_SEEN}}, // error seen
      // ignored, then end
      '{8'h41, 1'b1, 1'b1, '{16'h0000, 1'b0, escdec_pkg::STATUS_ENDED_INVALID}},
      // escape unfinished
      '{8'h5C, 1'b1, 1'b1, '{16'h0000, 1'b0, escdec_pkg::STATUS_ENDED_INVALID}},
      '{8'h5C, 1'b0, 1'b1, '{16'h0000, 1'b0, escdec_pkg::STATUS_RUNNING}},
      // error on last byte
      '{8'h78, 1'b1, 1'b1, '{16'h0000, 1'b0, escdec_pkg::STATUS_ENDED_INVALID}},
      // clean after end
      '{8'h41, 1'b1, 1'b1, '{16'h0041, 1'b1, escdec_pkg::STATUS_ENDED_VALID}}
   };

   // clock
   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic logic is_decimal(input logic [escdec_pkg::BYTE_WIDTH-1:0] data);
      return data >= escdec_pkg::CHAR_DIGIT_0 && data <= escdec_pkg::CHAR_DIGIT_9;
   endfunction

   function automatic logic is_hex_letter(input logic [escdec_pkg::BYTE_WIDTH-1:0] folded);
      return folded >= escdec_pkg::CHAR_UPPER_A && folded <= escdec_pkg::CHAR_UPPER_F;
   endfunction

   // decode of one accepted request, advancing the checker's state
   function automatic escdec_pkg::result_type decode_step(
         input logic [escdec_pkg::BYTE_WIDTH-1:0] data, input logic is_last);
      escdec_pkg::result_type            res;
      logic [escdec_pkg::BYTE_WIDTH-1:0] folded;
      logic [3:0]                        digit;
      logic                              emit;
      folded = data;
      digit  = 4'(data - escdec_pkg::CHAR_DIGIT_0);
      emit   = 1'b0;
      if (dec_mode != escdec_pkg::MODE_ERROR) begin
         case (dec_mode)
            escdec_pkg::MODE_PLAIN: begin
               if (data == escdec_pkg::CHAR_BACKSLASH) dec_mode = escdec_pkg::MODE_BACKSLASH;
               else if (!data[7]) dec_value = {8'h00, data};
               else dec_mode = escdec_pkg::MODE_ERROR;
            end
            escdec_pkg::MODE_BACKSLASH: begin
               if (data == escdec_pkg::CHAR_UPPER_U || data == escdec_pkg::CHAR_LOWER_U) begin
                  dec_mode  = escdec_pkg::MODE_HEX_1;
                  dec_value = '0;
               end else if (is_decimal(data)) begin
                  dec_mode  = escdec_pkg::MODE_OCT_2;
                  dec_value = {12'h000, digit};
               end else if (data == escdec_pkg::CHAR_BACKSLASH) begin
                  dec_mode  = escdec_pkg::MODE_PLAIN;
                  dec_value = {8'h00, data};
               end else begin
                  dec_mode = escdec_pkg::MODE_ERROR;
               end
            end
            escdec_pkg::MODE_HEX_1, escdec_pkg::MODE_HEX_2,
            escdec_pkg::MODE_HEX_3, escdec_pkg::MODE_HEX_4: begin
               // letters fold to upper case before the range test
               if (data >= escdec_pkg::CHAR_LOWER_A) folded = data - escdec_pkg::CASE_OFFSET;
               if (!is_decimal(data) && is_hex_letter(folded))
                  digit = 4'(folded - escdec_pkg::CHAR_UPPER_A) + 4'd10;
               if (is_decimal(data) || is_hex_letter(folded)) begin
                  dec_value = (dec_value << 4) | {12'h000, digit};
                  dec_mode  = (dec_mode == escdec_pkg::MODE_HEX_4) ? escdec_pkg::MODE_PLAIN
                              : escdec_pkg::mode_type'(dec_mode + 4'd1);
               end else begin
                  dec_mode = escdec_pkg::MODE_ERROR;
               end
            end
            escdec_pkg::MODE_OCT_2, escdec_pkg::MODE_OCT_3: begin
               // digits are merged by or, so 8 and 9 overlap the shifted value
               if (is_decimal(data)) begin
                  dec_value = (dec_value << 3) | {12'h000, digit};
                  dec_mode  = (dec_mode == escdec_pkg::MODE_OCT_3) ? escdec_pkg::MODE_PLAIN
                              : escdec_pkg::mode_type'(dec_mode + 4'd1);
               end else begin
                  dec_mode = escdec_pkg::MODE_ERROR;
               end
            end
            default: dec_mode = escdec_pkg::MODE_ERROR;
         endcase
         emit = (dec_mode == escdec_pkg::MODE_PLAIN);
      end
      if (is_last)
         res.status = (dec_mode == escdec_pkg::MODE_PLAIN) ? escdec_pkg::STATUS_ENDED_VALID
                                                          : escdec_pkg::STATUS_ENDED_INVALID;
      else
         res.status = (dec_mode == escdec_pkg::MODE_ERROR) ? escdec_pkg::STATUS_ERROR_SEEN
                                                          : escdec_pkg::STATUS_RUNNING;
      res.code_unit  = emit ? dec_value : '0;
      res.unit_valid = emit;
      // end of stream clears the escape state
      if (is_last) begin
         dec_mode  = escdec_pkg::MODE_PLAIN;
         dec_value = '0;
      end
      return res;
   endfunction

   // idle length before a request: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [escdec_pkg::BYTE_WIDTH-1:0] hex_char(input int value,
                                                                  input bit upper);
      if (value < 10) return escdec_pkg::CHAR_DIGIT_0 + escdec_pkg::BYTE_WIDTH'(value);
      return (upper ? escdec_pkg::CHAR_UPPER_A : escdec_pkg::CHAR_LOWER_A) +
             escdec_pkg::BYTE_WIDTH'(value - 10);
   endfunction

   // one well-formed token appended to the stream
   function automatic void add_token();
      int                                r;
      token_kind_type                    kind;
      logic [escdec_pkg::BYTE_WIDTH-1:0] ch;
      r = $urandom_range(0, 9);
      kind = (r < 4) ? TOKEN_PLAIN : (r < 5) ? TOKEN_PAIR : (r < 8) ? TOKEN_HEX : TOKEN_OCTAL;
      case (kind)
         TOKEN_PLAIN: begin
            ch = escdec_pkg::BYTE_WIDTH'($urandom_range(0, 127));
            if (ch == escdec_pkg::CHAR_BACKSLASH) ch = ch + 8'd1;
            stream_bytes.push_back(ch);
         end
         TOKEN_PAIR: begin
            stream_bytes.push_back(escdec_pkg::CHAR_BACKSLASH);
            stream_bytes.push_back(escdec_pkg::CHAR_BACKSLASH);
         end
         TOKEN_HEX: begin
            stream_bytes.push_back(escdec_pkg::CHAR_BACKSLASH);
            stream_bytes.push_back($urandom_range(0, 1) ? escdec_pkg::CHAR_UPPER_U
                                                         : escdec_pkg::CHAR_LOWER_U);
            repeat (4) stream_bytes.push_back(hex_char(int'($urandom_range(0, 15)),
                                                       1'($urandom_range(0, 1))));
         end
         default: begin
            stream_bytes.push_back(escdec_pkg::CHAR_BACKSLASH);
            repeat (3) stream_bytes.push_back(escdec_pkg::CHAR_DIGIT_0 +
                                              escdec_pkg::BYTE_WIDTH'($urandom_range(0, 9)));
         end
      endcase
   endfunction

   // random stream: mostly well formed, some with a stray byte, cut short or pure noise
   function automatic void build_stream();
      int r;
      stream_bytes.delete();
      repeat ($urandom_range(1, 10)) add_token();
      r = $urandom_range(0, 99);
      if (r < 8) begin
         stream_bytes.insert($urandom_range(0, stream_bytes.size()),
                             escdec_pkg::BYTE_WIDTH'($urandom_range(0, 255)));
      end else if (r < 12 && stream_bytes.size() > 2) begin
         repeat ($urandom_range(1, 2)) void'(stream_bytes.pop_back());
      end else if (r < 15) begin
         stream_bytes.delete();
         repeat ($urandom_range(1, 6))
            stream_bytes.push_back(escdec_pkg::BYTE_WIDTH'($urandom_range(0, 255)));
      end
   endfunction

   // offer one request, wait for it to be taken, then record its response
   task automatic send_request(input logic [escdec_pkg::BYTE_WIDTH-1:0] data,
                               input logic is_last, input logic pinned,
                               input escdec_pkg::result_type pinned_res);
      int                     gap;
      escdec_pkg::result_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.byte_in <= data;
      req_ch.last    <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = decode_step(data, is_last);
      sent_requests++;
      expected_results.push_back(pinned ? pinned_res : predicted);
      @(negedge clock);
   endtask

   task automatic report(input string field, input int want, input int got);
      failures++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
   endtask

   // stimulus
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.byte_in = '0;
      req_ch.last    = 1'b0;
      dec_mode       = escdec_pkg::MODE_PLAIN;
      dec_value      = '0;
      failures       = 0;
      sent_requests  = 0;
      quiet          = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].pinned, directed_rows[i].want);

      while (sent_requests < ITEM_TARGET) begin
         quiet = ($urandom_range(0, 9) == 0);
         build_stream();
         foreach (stream_bytes[i])
            send_request(stream_bytes[i], i == stream_bytes.size() - 1, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;
      quiet = 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("escaped_ascii_to_utf16_decoder test passed");
      else
         $display("escaped_ascii_to_utf16_decoder test failed");
      $finish;
   end

   // response side: random stalls and one long hold-off while requests keep coming
   initial begin
      int stall_left;
      int r;
      bit hold_done;
      stall_left   = 0;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (!hold_done && sent_requests >= HOLD_AFTER) begin
            hold_done    = 1'b1;
            stall_left   = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               stall_left   = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
         end
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin
      escdec_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            report("unexpected response", 0,
                   int'({rsp_ch.code_unit, rsp_ch.unit_valid, rsp_ch.status}));
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.code_unit !== want.code_unit)
               report("code_unit", int'(want.code_unit), int'(rsp_ch.code_unit));
            if (rsp_ch.unit_valid !== want.unit_valid)
               report("unit_valid", int'(want.unit_valid), int'(rsp_ch.unit_valid));
            if (rsp_ch.status !== want.status)
               report("status", int'(want.status), int'(rsp_ch.status));
         end
      end
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("escaped_ascii_to_utf16_decoder test failed");
         $finish;
      end
   end

endmodule
